// ===== rtl/isc_pkg.sv =====
// Shared types and constants for the insertion sort unit.
package isc_pkg;

  // Fixed widths of the result fields.
  localparam int KEY_BITS = 16;
  localparam int CMP_BITS = 7;
  localparam int XCH_BITS = 8;

  // Saturation limits of the two counters.
  localparam logic [CMP_BITS-1:0] CMP_MAX = '1;
  localparam logic [XCH_BITS-1:0] XCH_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the incoming key at the fill position
    logic start_sort; // clear counters, first held index is one
    logic rd_held;    // read the key at the held index
    logic take_held;  // latch the held key, position follows held index
    logic rd_prev;    // read the key left of the position
    logic shift;      // move the read key right, count compare and exchange
    logic stop;       // key not greater, count the compare only
    logic place;      // write the held key, count the exchange
    logic emit_rd;    // read the next key for output
    logic finish;     // batch delivered, clear fill and output index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic batch_end;  // incoming key closes the batch
    logic single;     // incoming key would be the only one of the batch
    logic pos_zero;   // position reached the front of the buffer
    logic held_lt;    // held key is less than the key just read
    logic i_last;     // held index is the last key of the batch
    logic k_last;     // output index is the last key of the batch
  } status_t;

endpackage

// ===== rtl/isc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module isc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/isc_datapath.sv =====
// Datapath of the insertion sort unit: key buffer, indexes and counters.
module isc_datapath #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  isc_pkg::cmd_t                   cmd,
  output isc_pkg::status_t                status,
  input  logic [isc_pkg::KEY_BITS-1:0]    key,
  input  logic                            last,
  output logic [isc_pkg::KEY_BITS-1:0]    sorted_key,
  output logic [isc_pkg::CMP_BITS-1:0]    compares,
  output logic [isc_pkg::XCH_BITS-1:0]    exchanges
);

  localparam int KB = isc_pkg::KEY_BITS;
  localparam int CW = isc_pkg::CMP_BITS;
  localparam int XW = isc_pkg::XCH_BITS;
  localparam int SW = (KEY_WIDTH < KB) ? KEY_WIDTH : KB;
  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);

  logic [FW-1:0]               fill;
  logic [AW-1:0]               i;
  logic [AW-1:0]               pos;
  logic [AW-1:0]               k;
  logic [SW-1:0]               held;
  logic [isc_pkg::CMP_BITS-1:0] compare_count;
  logic [isc_pkg::XCH_BITS-1:0] exchange_count;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata;

  isc_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Write port: loaded keys, shifted keys and the placed held key.
  always_comb begin
    we    = cmd.load | cmd.shift | cmd.place;
    waddr = pos;
    wdata = held;
    if (cmd.load) begin
      waddr = fill[AW-1:0];
      wdata = key[SW-1:0];
    end else if (cmd.shift) begin
      wdata = rdata;
    end
  end

  // Read port address follows the active step.
  always_comb begin
    raddr = k;
    if (cmd.rd_held) begin
      raddr = i;
    end else if (cmd.rd_prev) begin
      raddr = pos - AW'(1);
    end
  end

  // Status for the controller.
  always_comb begin
    status.batch_end = last | (fill + FW'(1) == FW'(CAPACITY));
    status.single    = (fill == '0);
    status.pos_zero  = (pos == '0);
    status.held_lt   = (held < rdata);
    status.i_last    = (FW'(i) + FW'(1) == fill);
    status.k_last    = (FW'(k) + FW'(1) == fill);
  end

  // Fill count, indexes and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      i              <= '0;
      pos            <= '0;
      k              <= '0;
      compare_count  <= '0;
      exchange_count <= '0;
    end else begin
      if (cmd.load) begin
        fill <= fill + FW'(1);
      end
      if (cmd.start_sort) begin
        i              <= AW'(1);
        pos            <= '0;
        compare_count  <= '0;
        exchange_count <= '0;
      end
      if (cmd.take_held) begin
        pos <= i;
      end
      if (cmd.shift) begin
        pos <= pos - AW'(1);
      end
      if (cmd.shift || cmd.stop) begin
        if (compare_count != isc_pkg::CMP_MAX) begin
          compare_count <= compare_count + CW'(1);
        end
      end
      if (cmd.shift || cmd.place) begin
        if (exchange_count != isc_pkg::XCH_MAX) begin
          exchange_count <= exchange_count + XW'(1);
        end
      end
      if (cmd.place && !status.i_last) begin
        i <= i + AW'(1);
      end
      if (cmd.emit_rd) begin
        k <= k + AW'(1);
      end
      if (cmd.finish) begin
        fill <= '0;
        k    <= '0;
      end
    end
  end

  // The held key is captured from the read port.
  always_ff @(posedge clk) begin
    if (cmd.take_held) begin
      held <= rdata;
    end
  end

  assign sorted_key = KB'(rdata);
  assign compares   = compare_count;
  assign exchanges  = exchange_count;

`ifndef SYNTHESIS
  // The scan position never passes the held index.
  a_pos_le_i: assert property (@(posedge clk) disable iff (rst) pos <= i)
    else $error("scan position beyond held index");

  // The buffer never holds more keys than its capacity.
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY))
    else $error("fill count beyond capacity");
`endif

endmodule

// ===== rtl/isc_ctrl.sv =====
// Controller of the insertion sort unit: load, sort and emit sequencing.
module isc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              result_valid,
  output logic              last_res,
  input  isc_pkg::status_t  status,
  output isc_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    LOAD,
    HELD_RD,
    HELD_TAKE,
    PREV_RD,
    PREV_CMP,
    PLACE,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != LOAD);
  assign accept = start & ~busy;

  // Next state and commands to the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      LOAD: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (status.batch_end) begin
            cmd.start_sort = 1'b1;
            state_next     = status.single ? EMIT : HELD_RD;
          end
        end
      end
      HELD_RD: begin
        cmd.rd_held = 1'b1;
        state_next  = HELD_TAKE;
      end
      HELD_TAKE: begin
        cmd.take_held = 1'b1;
        state_next    = PREV_RD;
      end
      PREV_RD: begin
        if (status.pos_zero) begin
          state_next = PLACE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = PREV_CMP;
        end
      end
      PREV_CMP: begin
        if (status.held_lt) begin
          cmd.shift  = 1'b1;
          state_next = PREV_RD;
        end else begin
          cmd.stop   = 1'b1;
          state_next = PLACE;
        end
      end
      PLACE: begin
        cmd.place  = 1'b1;
        state_next = status.i_last ? EMIT : HELD_RD;
      end
      EMIT: begin
        cmd.emit_rd = 1'b1;
        if (status.k_last) begin
          cmd.finish = 1'b1;
          state_next = LOAD;
        end
      end
      default: begin
        state_next = LOAD;
      end
    endcase
  end

  // State and the registered result strobe, aligned with the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      result_valid <= 1'b0;
      last_res     <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == EMIT);
      last_res     <= (state == EMIT) && status.k_last;
    end
  end

`ifndef SYNTHESIS
  // A result burst runs without gaps until the flagged final result.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_res |=> result_valid)
    else $error("gap inside result burst");

  // Every compare step follows a read of the left neighbor.
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == PREV_CMP |-> $past(state) == PREV_RD)
    else $error("compare without preceding read");

  // The final flag only comes with a result.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_res |-> result_valid && $past(state) == EMIT)
    else $error("final flag without result");
`endif

endmodule

// ===== rtl/insertion_sort_with_counts_unit.sv =====
// Top level of the insertion sort unit with compare and exchange counts.
//
// Keys load one per cycle while busy is low; a key transfers at a clock edge with start high and
// busy low. The key flagged last, or the key that fills the buffer to CAPACITY, starts a stable
// ascending insertion sort of the batch in a single buffer RAM with one write and one registered
// read port. Each scan step reads the left neighbor, then compares it and shifts it right or
// stops the scan. Each key after the first is read, taken and placed around its scan, with an
// extra step when its scan reaches the front of the buffer. The sorted keys then come out one
// per cycle, each marked by result_valid for exactly one cycle, with last_res on the final one
// and both counts on every one. The receiver cannot stall the results. The next key can
// transfer in the cycle that shows the final result.
module insertion_sort_with_counts_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [isc_pkg::KEY_BITS-1:0]  key,
  input  logic                          last,
  output logic                          result_valid,
  output logic [isc_pkg::KEY_BITS-1:0]  sorted_key,
  output logic                          last_res,
  output logic [isc_pkg::CMP_BITS-1:0]  compares,
  output logic [isc_pkg::XCH_BITS-1:0]  exchanges
);

  isc_pkg::cmd_t    cmd;
  isc_pkg::status_t status;

  // Sequencing of load, sort and output.
  isc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last_res     (last_res),
    .status       (status),
    .cmd          (cmd)
  );

  // Key storage, scan indexes and counters.
  isc_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .key        (key),
    .last       (last),
    .sorted_key (sorted_key),
    .compares   (compares),
    .exchanges  (exchanges)
  );

endmodule
